// ===== src/c2d_pkg.sv =====
// shared constants, field widths and types for the 2-d convolution block
// no dependencies; imported by every module under src
package c2d_pkg;

    localparam int KERNEL_DEF      = 5;
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int FRAC_BITS_DEF   = 8;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int OPC_W    = 1;
    localparam int CIDX_W   = 5;
    localparam int COEF_W   = 16;
    localparam int PIX_W    = 16;
    localparam int RESULT_W = 32;
    localparam int ROW_W    = 12;
    localparam int COL_W    = 10;
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 56;

    localparam logic [OPC_W-1:0] OP_COEF  = 1'b0;
    localparam logic [OPC_W-1:0] OP_PIXEL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } meta_t;

endpackage

// ===== src/c2d_line.sv =====
// line store: one bank per window row, written at the pixel column
// depends on c2d_pkg
module c2d_line
    import c2d_pkg::*;
#(
    parameter int KERNEL      = KERNEL_DEF,
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [((KERNEL > 1) ? $clog2(KERNEL) : 1)-1:0] wr_slot,
    input  logic [$clog2(MAX_WIDTH)-1:0]  addr,
    input  logic signed [SAMPLE_BITS-1:0] wr_data,
    input  logic                          rd_en,
    output logic signed [SAMPLE_BITS-1:0] rd_data [KERNEL]
);

    localparam int SW = (KERNEL > 1) ? $clog2(KERNEL) : 1;

    for (genvar b = 0; b < KERNEL; b++)
    begin : g_bank
        logic signed [SAMPLE_BITS-1:0] mem [MAX_WIDTH];

        always_ff @(posedge clk)
        begin
            if (wr_en && wr_slot == SW'(b))
            begin
                mem[addr] <= wr_data;
            end
            if (rd_en)
            begin
                rd_data[b] <= mem[addr];
            end
        end
    end

endmodule

// ===== src/c2d_cell.sv =====
// one window column cell; takes the column of its right neighbor on each push
// depends on c2d_pkg
module c2d_cell
    import c2d_pkg::*;
#(
    parameter int KERNEL      = KERNEL_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          shift,
    input  logic signed [SAMPLE_BITS-1:0] col_in  [KERNEL],
    output logic signed [SAMPLE_BITS-1:0] col_out [KERNEL]
);

    logic signed [SAMPLE_BITS-1:0] col_reg [KERNEL];

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule

// ===== src/c2d_mac.sv =====
// product, row-sum and total stages for one window per cycle while en is high
// depends on c2d_pkg
module c2d_mac
    import c2d_pkg::*;
#(
    parameter int KERNEL      = KERNEL_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [SAMPLE_BITS-1:0] taps  [KERNEL*KERNEL],
    input  logic signed [COEF_W-1:0]      coefs [KERNEL*KERNEL],
    input  meta_t                         in_meta,
    output logic                          out_valid,
    output logic signed [RESULT_W-1:0]    out_sum,
    output meta_t                         out_meta
);

    localparam int NTAP = KERNEL * KERNEL;
    localparam int PW   = SAMPLE_BITS + COEF_W;

    logic signed [PW-1:0]       prod    [NTAP];
    logic signed [PW-1:0]       prod_sh [NTAP];
    logic signed [RESULT_W-1:0] p_reg   [NTAP];
    logic signed [RESULT_W-1:0] r_next  [KERNEL];
    logic signed [RESULT_W-1:0] r_reg   [KERNEL];
    logic signed [RESULT_W-1:0] t_next;
    logic signed [RESULT_W-1:0] t_reg;
    logic  p_valid_reg, r_valid_reg, t_valid_reg;
    meta_t p_meta_reg, r_meta_reg, t_meta_reg;

    // floor shift of the exact product, then wrap to the sum width
    always_comb
    begin
        for (int t = 0; t < NTAP; t++)
        begin
            prod[t]    = taps[t] * coefs[t];
            prod_sh[t] = prod[t] >>> FRAC_BITS;
        end
    end

    always_comb
    begin
        for (int i = 0; i < KERNEL; i++)
        begin
            r_next[i] = '0;
            for (int j = 0; j < KERNEL; j++)
            begin
                r_next[i] = r_next[i] + p_reg[i*KERNEL+j];
            end
        end
        t_next = '0;
        for (int i = 0; i < KERNEL; i++)
        begin
            t_next = t_next + r_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
            t_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg <= in_valid;
            r_valid_reg <= p_valid_reg;
            t_valid_reg <= r_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int t = 0; t < NTAP; t++)
            begin
                p_reg[t] <= RESULT_W'(prod_sh[t]);
            end
            r_reg      <= r_next;
            t_reg      <= t_next;
            p_meta_reg <= in_meta;
            r_meta_reg <= p_meta_reg;
            t_meta_reg <= r_meta_reg;
        end
    end

    assign out_valid = t_valid_reg;
    assign out_sum   = t_reg;
    assign out_meta  = t_meta_reg;

endmodule

// ===== src/conv2d_5x5_fixed_point_same.sv =====
// top level: frame position, line store, column cell chain, result sequencer,
// mac pipeline and output skid; depends on c2d_pkg, c2d_line, c2d_cell, c2d_mac
//
// channel   dir  handshake            contents
// s_*       in   s_tvalid/s_tready    tuser: opcode; tdata: coef_index, coef_value, pixel
// m_*       out  m_tvalid/m_tready    tdata: result, out_row, out_col; tlast: run_last
// cfg_*     in   cfg_we               cfg_index selects width or height, cfg_data value
//
// inside the image one pixel is taken per cycle unless the output stalls; a pixel in
// the last column or last row holds input until all of its results are issued, up to
// (KERNEL-KERNEL/2)^2 of them, as the single mac pipeline takes one window per cycle
// while the output is not stalled.
// reset needs no clearing pass: rows and columns outside the frame are masked.
// a stalled output parks one word in a skid stage, then input stops.
module conv2d_5x5_fixed_point_same
    import c2d_pkg::*;
#(
    parameter int KERNEL      = KERNEL_DEF,
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // coef_index, coef_value, pixel
    input  logic [OPC_W-1:0]      s_tuser,   // opcode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // result, out_row, out_col
    output logic                  m_tlast
);

    localparam int K_HI = KERNEL - 1 - KERNEL / 2;
    localparam int NTAP = KERNEL * KERNEL;
    localparam int SW   = (KERNEL > 1) ? $clog2(KERNEL) : 1;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int EW   = (WW > WIDTH_W) ? WW : WIDTH_W;
    localparam int DW   = (K_HI > 0) ? $clog2(K_HI + 1) : 1;
    localparam int SB   = SAMPLE_BITS;

    // input word fields
    logic [OPC_W-1:0]         in_op;
    logic [CIDX_W-1:0]        in_cidx;
    logic signed [COEF_W-1:0] in_cval;
    logic [PIX_W-1:0]         in_pix;
    logic signed [SB-1:0]     in_sample;

    assign in_op   = s_tuser;
    assign in_cidx = s_tdata[CIDX_W-1:0];
    assign in_cval = s_tdata[CIDX_W+COEF_W-1:CIDX_W];
    assign in_pix  = s_tdata[CIDX_W+COEF_W+PIX_W-1:CIDX_W+COEF_W];

    if (SB <= PIX_W)
    begin : g_samp_narrow
        assign in_sample = in_pix[SB-1:0];
    end
    else
    begin : g_samp_wide
        assign in_sample = {{(SB-PIX_W){1'b0}}, in_pix};
    end

    // configuration
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [CW-1:0]       w_last;
    logic [ROW_W-1:0]    h_last;
    logic                cfg_hit;

    always_comb
    begin
        case (cfg_index)
            CFG_WIDTH:  cfg_hit = cfg_we;
            CFG_HEIGHT: cfg_hit = cfg_we;
            default:    cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_W'(1024);
            height_reg <= HEIGHT_W'(1024);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_last = '0;
        end
        else if (EW'(width_reg) > EW'(MAX_WIDTH))
        begin
            w_last = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last = CW'(width_reg - 1'b1);
        end
        h_last = (height_reg == '0) ? '0 : ROW_W'(height_reg - 1'b1);
    end

    // pipeline control
    logic en;
    logic acc, pix_acc;
    logic s1_valid_reg;
    logic seq_busy_reg, seq_last, seq_done, seq_free, issue;
    logic s1_adv, push;

    assign acc      = s_tvalid && s_tready;
    assign pix_acc  = acc && (in_op == OP_PIXEL);
    assign issue    = en && seq_busy_reg;
    assign seq_done = issue && seq_last;
    assign seq_free = !seq_busy_reg || seq_done;
    assign s_tready = en && (!s1_valid_reg || seq_free);

    // frame position of the next pixel
    logic [ROW_W-1:0] row_reg;
    logic [CW-1:0]    col_reg;
    logic [SW-1:0]    slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            slot_reg <= '0;
        end
        else if (cfg_hit)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            slot_reg <= '0;
        end
        else if (pix_acc)
        begin
            if (col_reg == w_last)
            begin
                col_reg <= '0;
                if (row_reg == h_last)
                begin
                    row_reg  <= '0;
                    slot_reg <= '0;
                end
                else
                begin
                    row_reg  <= row_reg + 1'b1;
                    slot_reg <= (slot_reg == SW'(KERNEL - 1)) ? '0 : slot_reg + 1'b1;
                end
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // line store, read data lands together with the stage 1 word
    logic signed [SB-1:0] rd_data [KERNEL];

    c2d_line #(
        .KERNEL      (KERNEL),
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SB)
    ) u_line (
        .clk     (clk),
        .wr_en   (pix_acc),
        .wr_slot (slot_reg),
        .addr    (col_reg),
        .wr_data (in_sample),
        .rd_en   (pix_acc),
        .rd_data (rd_data)
    );

    // stage 1
    logic [OPC_W-1:0]         s1_op_reg;
    logic [CIDX_W-1:0]        s1_cidx_reg;
    logic signed [COEF_W-1:0] s1_cval_reg;
    logic signed [SB-1:0]     s1_sample_reg;
    logic [ROW_W-1:0]         s1_row_reg;
    logic [CW-1:0]            s1_col_reg;
    logic [SW-1:0]            s1_slot_reg;
    logic                     s1_last_row_reg, s1_last_col_reg;

    assign s1_adv = en && s1_valid_reg && seq_free;
    assign push   = s1_adv && (s1_op_reg == OP_PIXEL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (acc)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_op_reg       <= in_op;
            s1_cidx_reg     <= in_cidx;
            s1_cval_reg     <= in_cval;
            s1_sample_reg   <= in_sample;
            s1_row_reg      <= row_reg;
            s1_col_reg      <= col_reg;
            s1_slot_reg     <= slot_reg;
            s1_last_row_reg <= (row_reg == h_last);
            s1_last_col_reg <= (col_reg == w_last);
        end
    end

    // new column, oldest row first; rows above the frame read as zero
    logic signed [SB-1:0] new_col [KERNEL];

    always_comb
    begin
        int bs;
        for (int m = 0; m < KERNEL; m++)
        begin
            new_col[m] = '0;
            if (m == KERNEL - 1)
            begin
                new_col[m] = s1_sample_reg;
            end
            else
            begin
                bs = int'(s1_slot_reg) + 1 + m;
                if (bs >= KERNEL)
                begin
                    bs = bs - KERNEL;
                end
                for (int b = 0; b < KERNEL; b++)
                begin
                    if (bs == b)
                    begin
                        new_col[m] = rd_data[b];
                    end
                end
            end
            if (s1_row_reg < ROW_W'(KERNEL - 1 - m))
            begin
                new_col[m] = '0;
            end
        end
    end

    // chain of column cells, cell KERNEL-1 holds the newest column
    logic signed [SB-1:0] win [KERNEL][KERNEL];

    for (genvar m = 0; m < KERNEL; m++)
    begin : g_cell
        if (m == KERNEL - 1)
        begin : g_head
            c2d_cell #(
                .KERNEL      (KERNEL),
                .SAMPLE_BITS (SB)
            ) u_cell (
                .clk     (clk),
                .shift   (push),
                .col_in  (new_col),
                .col_out (win[m])
            );
        end
        else
        begin : g_body
            c2d_cell #(
                .KERNEL      (KERNEL),
                .SAMPLE_BITS (SB)
            ) u_cell (
                .clk     (clk),
                .shift   (push),
                .col_in  (win[m+1]),
                .col_out (win[m])
            );
        end
    end

    // coefficients, updated in order with the pixel words
    logic signed [COEF_W-1:0] coef_reg [NTAP];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < NTAP; t++)
            begin
                coef_reg[t] <= '0;
            end
        end
        else if (s1_adv && s1_op_reg == OP_COEF)
        begin
            for (int t = 0; t < NTAP; t++)
            begin
                if (int'(s1_cidx_reg) == t)
                begin
                    coef_reg[t] <= s1_cval_reg;
                end
            end
        end
    end

    // result sequencer: row offset d, column offset k over a frozen window
    logic [DW-1:0]     seq_d_reg, seq_k_reg;
    logic [DW-1:0]     seq_dhi_reg, seq_klo_reg, seq_khi_reg;
    logic [ROW_W-1:0]  seq_row_reg;
    logic [CW-1:0]     seq_col_reg;
    logic [KERNEL-1:0] seq_cmask_reg;
    logic              row_ok, col_ok;
    logic [DW-1:0]     dlo_next, dhi_next, klo_next, khi_next;
    logic [KERNEL-1:0] cmask_next;

    assign seq_last = (seq_d_reg == seq_dhi_reg) && (seq_k_reg == seq_khi_reg);

    always_comb
    begin
        row_ok   = s1_last_row_reg || (s1_row_reg >= ROW_W'(K_HI));
        col_ok   = s1_last_col_reg || (s1_col_reg >= CW'(K_HI));
        dhi_next = s1_last_row_reg ? DW'(K_HI) : '0;
        khi_next = s1_last_col_reg ? DW'(K_HI) : '0;
        dlo_next = '0;
        klo_next = '0;
        // windows clamped at the top or left edge of a small frame
        if (s1_last_row_reg && s1_row_reg < ROW_W'(K_HI))
        begin
            dlo_next = DW'(K_HI - int'(s1_row_reg));
        end
        if (s1_last_col_reg && s1_col_reg < CW'(K_HI))
        begin
            klo_next = DW'(K_HI - int'(s1_col_reg));
        end
        for (int m = 0; m < KERNEL; m++)
        begin
            cmask_next[m] = (s1_col_reg >= CW'(KERNEL - 1 - m));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_busy_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            seq_busy_reg <= (s1_op_reg == OP_PIXEL) && row_ok && col_ok;
        end
        else if (seq_done)
        begin
            seq_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            seq_d_reg     <= dlo_next;
            seq_k_reg     <= klo_next;
            seq_dhi_reg   <= dhi_next;
            seq_klo_reg   <= klo_next;
            seq_khi_reg   <= khi_next;
            seq_row_reg   <= s1_row_reg;
            seq_col_reg   <= s1_col_reg;
            seq_cmask_reg <= cmask_next;
        end
        else if (issue)
        begin
            if (seq_k_reg == seq_khi_reg)
            begin
                seq_k_reg <= seq_klo_reg;
                seq_d_reg <= seq_d_reg + 1'b1;
            end
            else
            begin
                seq_k_reg <= seq_k_reg + 1'b1;
            end
        end
    end

    // window select: taps past the newest row or column, or left of the frame, are zero padding
    logic signed [SB-1:0] taps [NTAP];
    meta_t                issue_meta;

    always_comb
    begin
        for (int i = 0; i < KERNEL; i++)
        begin
            for (int j = 0; j < KERNEL; j++)
            begin
                taps[i*KERNEL+j] = '0;
                for (int dd = 0; dd <= K_HI; dd++)
                begin
                    for (int kk = 0; kk <= K_HI; kk++)
                    begin
                        if (i + dd < KERNEL && j + kk < KERNEL)
                        begin
                            if (seq_d_reg == DW'(dd) && seq_k_reg == DW'(kk)
                                && seq_cmask_reg[j+kk])
                            begin
                                taps[i*KERNEL+j] = win[j+kk][i+dd];
                            end
                        end
                    end
                end
            end
        end
        issue_meta.row  = seq_row_reg - ROW_W'(K_HI) + ROW_W'(seq_d_reg);
        issue_meta.col  = COL_W'(seq_col_reg - CW'(K_HI) + CW'(seq_k_reg));
        issue_meta.last = seq_last;
    end

    logic                       t_valid;
    logic signed [RESULT_W-1:0] t_sum;
    meta_t                      t_meta;

    c2d_mac #(
        .KERNEL      (KERNEL),
        .SAMPLE_BITS (SB),
        .FRAC_BITS   (FRAC_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (seq_busy_reg),
        .taps      (taps),
        .coefs     (coef_reg),
        .in_meta   (issue_meta),
        .out_valid (t_valid),
        .out_sum   (t_sum),
        .out_meta  (t_meta)
    );

    // output register with one skid word
    logic                       out_valid_reg, skid_valid_reg;
    logic signed [RESULT_W-1:0] out_sum_reg, skid_sum_reg;
    meta_t                      out_meta_reg, skid_meta_reg;
    logic                       out_free;

    assign en       = !skid_valid_reg;
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= t_valid;
            end
        end
        else if (t_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_sum_reg  <= skid_sum_reg;
                out_meta_reg <= skid_meta_reg;
            end
            else
            begin
                out_sum_reg  <= t_sum;
                out_meta_reg <= t_meta;
            end
        end
        else if (en && t_valid)
        begin
            skid_sum_reg  <= t_sum;
            skid_meta_reg <= t_meta;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'({out_meta_reg.col, out_meta_reg.row, out_sum_reg});
    assign m_tlast  = out_meta_reg.last;

    // window must not move while results are still being drawn from it
    a_push_free : assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!seq_busy_reg || seq_last))
        else $error("window pushed while sequencer busy");

    a_seq_range : assert property (@(posedge clk) disable iff (!rst_n)
        seq_busy_reg |-> (seq_d_reg <= seq_dhi_reg && seq_k_reg <= seq_khi_reg))
        else $error("sequencer offset out of range");

    a_skid_fill : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid filled while output free");

    a_skid_stall : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |=> ($stable(t_sum) || !skid_valid_reg || !$past(skid_valid_reg)))
        else $error("mac moved while skid full");

endmodule

// ===== bench/conv2d_5x5_fixed_point_same_tb.sv =====
// testbench for conv2d_5x5_fixed_point_same: streams coefficients and pixel frames,
// predicts every output word in a scoreboard class; depends on c2d_pkg and the rtl
module conv2d_5x5_fixed_point_same_tb;
    import c2d_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int K    = KERNEL_DEF;
    localparam int KLO  = K / 2;
    localparam int KHI  = K - 1 - KLO;
    localparam int MAXW = MAX_WIDTH_DEF;

    typedef struct {
        logic [RESULT_W-1:0] sum;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic                last;
    } conv_out_t;

    class conv_scoreboard;
        logic signed [COEF_W-1:0] taps [K*K];
        logic signed [PIX_W-1:0]  lines [K][MAXW];
        int unsigned              cur_row, cur_col, width_reg, height_reg;
        conv_out_t                pending [$];
        int                       mismatches;
        int                       words_checked;

        function new();
            foreach (taps[i]) taps[i] = '0;
            cur_row = 0;
            cur_col = 0;
            width_reg = 1024;
            height_reg = 1024;
            mismatches = 0;
            words_checked = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
            if (idx == CFG_WIDTH) width_reg = 32'(v) & 32'h7ff;
            else height_reg = 32'(v);
            cur_row = 0;
            cur_col = 0;
        endfunction

        function logic [RESULT_W-1:0] window_sum(int orow, int ocol, int h, int w);
            logic [RESULT_W-1:0] acc;
            longint              prod;
            int                  r, c;
            acc = '0;
            for (int i = 0; i < K; i++)
            begin
                r = orow + i - KLO;
                if (r < 0 || r >= h) continue;
                for (int j = 0; j < K; j++)
                begin
                    c = ocol + j - KLO;
                    if (c < 0 || c >= w) continue;
                    prod = longint'(lines[r % K][c]) * longint'(taps[i*K+j]);
                    // arithmetic shift rounds toward minus infinity
                    acc += RESULT_W'(prod >>> FRAC_BITS_DEF);
                end
            end
            return acc;
        endfunction

        function void note_word(logic [OPC_W-1:0] opc, logic [CIDX_W-1:0] idx,
                                logic [COEF_W-1:0] cv, logic [PIX_W-1:0] px);
            int h, w, ir, ic, rlo, rhi, clo, chi;
            conv_out_t e;
            if (opc == OP_COEF)
            begin
                if (idx < K*K) taps[idx] = cv;
                return;
            end
            h = (height_reg == 0) ? 1 : height_reg;
            w = (width_reg == 0) ? 1 : ((width_reg > MAXW) ? MAXW : width_reg);
            ir = (cur_row >= h) ? h - 1 : cur_row;
            ic = (cur_col >= w) ? w - 1 : cur_col;
            lines[ir % K][ic] = px;
            if (ir + 1 < h)
            begin
                rlo = ir - KHI;
                rhi = rlo;
            end
            else
            begin
                rlo = (ir - KHI < 0) ? 0 : ir - KHI;
                rhi = ir;
            end
            if (ic + 1 < w)
            begin
                clo = ic - KHI;
                chi = clo;
            end
            else
            begin
                clo = (ic - KHI < 0) ? 0 : ic - KHI;
                chi = ic;
            end
            if (rlo >= 0 && clo >= 0)
            begin
                for (int r = rlo; r <= rhi; r++)
                begin
                    for (int c = clo; c <= chi; c++)
                    begin
                        e.sum  = window_sum(r, c, h, w);
                        e.row  = ROW_W'(r);
                        e.col  = COL_W'(c);
                        e.last = (r == rhi && c == chi);
                        pending.push_back(e);
                    end
                end
            end
            if (ic + 1 < w)
            begin
                cur_col = ic + 1;
                cur_row = ir;
            end
            else
            begin
                cur_col = 0;
                cur_row = (ir + 1 < h) ? ir + 1 : 0;
            end
        endfunction

        function void check_word(logic [M_DATA_W-1:0] d, logic last);
            conv_out_t e;
            logic [RESULT_W-1:0] sum;
            logic [ROW_W-1:0]    row;
            logic [COL_W-1:0]    col;
            sum = d[RESULT_W-1:0];
            row = d[RESULT_W +: ROW_W];
            col = d[RESULT_W+ROW_W +: COL_W];
            words_checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: sum %0d row %0d col %0d last %0b",
                             $signed(sum), row, col, last);
                return;
            end
            e = pending.pop_front();
            if (sum !== e.sum || row !== e.row || col !== e.col || last !== e.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp sum %0d row %0d col %0d last %0b,",
                              " got sum %0d row %0d col %0d last %0b"},
                             $signed(e.sum), e.row, e.col, e.last,
                             $signed(sum), row, col, last);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;   // coef_index, coef_value, pixel, zero pad
    logic [OPC_W-1:0]      s_tuser;   // opcode
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;   // result, out_row, out_col, zero pad
    logic                  m_tlast;

    conv_scoreboard sb;
    int tx_idle_pct;
    int rx_idle_pct;
    logic rx_stall = 1'b0;
    event rx_hold_ev;
    int pixels_sent;
    int frames_sent;

    conv2d_5x5_fixed_point_same u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // receiver: check accepted words, then pick next ready
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast);
        if (rx_stall)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // long receiver hold, counted here in cycles
    always @(rx_hold_ev)
    begin
        rx_stall <= 1'b1;
        repeat (300) @(posedge clk);
        rx_stall <= 1'b0;
    end

    task automatic send_word(logic [OPC_W-1:0] opc, logic [CIDX_W-1:0] idx,
                             logic [COEF_W-1:0] cv, logic [PIX_W-1:0] px);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= opc;
        s_tdata  <= {3'b000, px, cv, idx};
        do @(posedge clk); while (!s_tready);
        sb.note_word(opc, idx, cv, px);
        if (opc == OP_PIXEL) pixels_sent++;
    endtask

    task automatic send_pixel(logic [PIX_W-1:0] px);
        send_word(OP_PIXEL, CIDX_W'($urandom), COEF_W'($urandom), px);
    endtask

    task automatic load_tap(logic [CIDX_W-1:0] idx, logic [COEF_W-1:0] cv);
        send_word(OP_COEF, idx, cv, PIX_W'($urandom));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        // coefficient words may still be in flight
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, v);
    endtask

    task automatic frame_size(int w, int h);
        write_reg(CFG_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_HEIGHT, CFG_DATA_W'(h));
    endtask

    task automatic random_frame(int w, int h);
        frame_size(w, h);
        frames_sent++;
        for (int i = 0; i < w * h; i++)
        begin
            if ($urandom_range(9) == 0)
                load_tap(CIDX_W'($urandom_range(31)), COEF_W'($urandom));
            send_pixel(PIX_W'($urandom));
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        pixels_sent = 0;
        frames_sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme taps, ignored tap indexes, extreme pixels
        frame_size(3, 3);
        load_tap(CIDX_W'(0), 16'h8000);
        load_tap(CIDX_W'(24), 16'h7fff);
        load_tap(CIDX_W'(12), 16'hffff);
        load_tap(CIDX_W'(25), 16'h1234);
        load_tap(CIDX_W'(31), 16'h7fff);
        for (int i = 1; i < 24; i++)
            if (i != 12) load_tap(CIDX_W'(i), COEF_W'($urandom));
        send_pixel(16'h8000);
        send_pixel(16'h7fff);
        send_pixel(16'h0000);
        load_tap(CIDX_W'(6), 16'h8000);   // load mid-frame keeps the position
        send_pixel(16'hffff);
        send_pixel(16'h8000);
        send_pixel(16'h7fff);
        send_pixel(16'h0001);
        send_pixel(16'h8000);
        send_pixel(16'h7fff);
        frame_size(0, 0);        // zero acts as one
        send_pixel(16'h7fff);
        frame_size(2047, 1);     // wide row acts as the maximum width
        for (int i = 0; i < 6; i++) send_pixel(PIX_W'($urandom));
        frame_size(1, 4095);     // tall frame, abandoned part way
        for (int i = 0; i < 4; i++) send_pixel(PIX_W'($urandom));
        frame_size(4, 2);
        for (int i = 0; i < 3; i++) send_pixel(PIX_W'($urandom));
        write_reg(CFG_HEIGHT, CFG_DATA_W'(3));  // write restarts the frame
        for (int i = 0; i < 12; i++) send_pixel(PIX_W'($urandom));

        pixels_sent = 0;
        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 87 : 0;
            rx_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 31 : 0;
            while (pixels_sent < 6 * (phase + 1))
                random_frame($urandom_range(1, 6), $urandom_range(1, 5));
        end

        // long receiver stall while pixels keep coming
        frame_size(4, 4);
        -> rx_hold_ev;
        for (int i = 0; i < 16; i++) send_pixel(PIX_W'($urandom));

        drain();
        $display("covered %0d random frames, every tap, clamped and restarted frames,",
                 frames_sent);
        $display("and %0d checked output words", sb.words_checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
